// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/grdda_pkg.sv =====
// ---------------------------------------------------------------------------
// grdda_pkg
// Constants, types and helpers of the grid ray DDA traversal block.
// ---------------------------------------------------------------------------
package grdda_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int MAP_COLS   = 32;
  localparam int MAP_ROWS   = 32;
  localparam int STORE_SIZE = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int CELL_W     = 11;

  localparam logic [31:0] STEP_SAT = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd2;

  // Request operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT,
    ST_DIV,
    ST_SIDE_X,
    ST_SIDE_Y,
    ST_WALK,
    ST_CHECK,
    ST_HPX,
    ST_HPY,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_UX,
    DIV_UY,
    DIV_QX,
    DIV_QY
  } div_sel_t;

  // Clamp to the signed 16-bit range
  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/grid_ray_dda_traversal.sv =====
// ---------------------------------------------------------------------------
// grid_ray_dda_traversal
// One-bit tile map in a synchronous RAM with a DDA ray caster on top.
// ---------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  request   start, taken when busy is low operation, tile_*, start_*, target_*
//  result    done, one-cycle strobe        hit, hit_distance, hit_point_*,
//                                          hit_cell_*, zero_direction
//  config    cfg_write                     cfg_addr, cfg_data
//
// A tile write never raises busy. A cast runs through PREP, squaring
// (SQ_A, SQ_B), the square root, two unit-step divisions, SIDE_X and SIDE_Y,
// then the walk (one tile RAM read per cell, WALK and CHECK), then two
// hit-point divisions on a hit or the final limit test on a miss, then EMIT,
// after which done rises. A cast with target equal to start goes from PREP
// back to IDLE and raises done with zero_direction set.
// After reset the tile RAM is cleared one entry a cycle while busy stays
// high. The result strobe cannot be stalled.
// ---------------------------------------------------------------------------
module grid_ray_dda_traversal (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [4:0]         tile_col,
  input  logic [4:0]         tile_row,
  input  logic               tile_solid,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic [15:0]        hit_distance,
  output logic signed [15:0] hit_point_x,
  output logic signed [15:0] hit_point_y,
  output logic signed [7:0]  hit_cell_col,
  output logic signed [7:0]  hit_cell_row,
  output logic               zero_direction
);
  import grdda_pkg::*;

  state_t state, state_next;

  // Configuration
  logic [5:0]  map_width;
  logic [5:0]  map_height;
  logic [15:0] max_distance;

  // Tile RAM
  logic              mem [STORE_SIZE];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_wdata;
  logic              mem_rdata;
  logic [ADDR_W-1:0] clr_cnt;

  // Cast datapath
  logic signed [15:0]       sx, sy, tx, ty;
  logic                     negx, negy;
  logic [15:0]              ax, ay;
  logic [32:0]              sq;
  logic [33:0]              root;
  logic [4:0]               sqrt_k;
  logic [16:0]              len;
  logic [33:0]              dvd;
  logic [17:0]              rem;
  logic [16:0]              dvs;
  logic [5:0]               div_cnt;
  div_sel_t                 div_sel;
  logic [31:0]              ux, uy;
  logic [33:0]              sidex, sidey;
  logic [17:0]              walk_dist;
  logic signed [CELL_W-1:0] cx, cy;
  logic                     inb;
  logic                     found;
  logic [17:0]              qx, qy;

  // Combinational helpers
  logic              accept;
  logic [11:0]       wr_addr;
  logic signed [16:0] dx_c, dy_c;
  logic [33:0]       sqrt_bit, sqrt_trial, root_nx;
  logic              sqrt_ge;
  logic [17:0]       rem_sh;
  logic              div_ge;
  logic [33:0]       quo;
  logic [8:0]        fac_x, fac_y;
  logic [40:0]       side_prod;
  logic              take_x;
  logic signed [CELL_W-1:0] cx_n, cy_n;
  logic              col_ok, row_ok;
  logic [11:0]       rd_addr;
  logic              inb_c;
  logic              limit_hit;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Tile RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= 6'd32;
      map_height   <= 6'd30;
      max_distance <= 16'd25600;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_MAP_WIDTH:    map_width    <= cfg_data[5:0];
        REG_MAP_HEIGHT:   map_height   <= cfg_data[5:0];
        REG_MAX_DISTANCE: max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // tile write address, row-major on the configured width
    wr_addr = 12'(tile_row) * 12'(map_width) + 12'(tile_col);

    dx_c = {tx[15], tx} - {sx[15], sx};
    dy_c = {ty[15], ty} - {sy[15], sy};

    // one restoring square root step: two radicand bits per cycle
    sqrt_bit   = 34'(1) << {sqrt_k, 1'b0};
    sqrt_trial = root + sqrt_bit;
    sqrt_ge    = ({1'b0, sq} >= sqrt_trial);
    root_nx    = sqrt_ge ? ((root >> 1) + sqrt_bit) : (root >> 1);

    // one restoring division step
    rem_sh = {rem[16:0], dvd[33]};
    div_ge = (rem_sh >= {1'b0, dvs});
    quo    = {dvd[32:0], div_ge};

    // distance to the first cell edge, as a fraction of one cell
    fac_x = negx ? {1'b0, sx[FRAC_BITS-1:0]} : 9'(ONE) - {1'b0, sx[FRAC_BITS-1:0]};
    fac_y = negy ? {1'b0, sy[FRAC_BITS-1:0]} : 9'(ONE) - {1'b0, sy[FRAC_BITS-1:0]};
    side_prod = (state == ST_SIDE_X) ? 41'(fac_x) * 41'(ux) : 41'(fac_y) * 41'(uy);

    // DDA step: ties go along y
    take_x = (sidex < sidey);
    cx_n   = cx;
    cy_n   = cy;
    if (take_x) begin
      cx_n = negx ? cx - CELL_W'(1) : cx + CELL_W'(1);
    end else begin
      cy_n = negy ? cy - CELL_W'(1) : cy + CELL_W'(1);
    end
    col_ok  = !cx_n[CELL_W-1] && (cx_n[CELL_W-2:0] < (CELL_W-1)'(map_width));
    row_ok  = !cy_n[CELL_W-1] && (cy_n[CELL_W-2:0] < (CELL_W-1)'(map_height));
    rd_addr = 12'(cy_n[5:0]) * 12'(map_width) + 12'(cx_n[5:0]);
    inb_c   = col_ok && row_ok && (rd_addr < 12'(STORE_SIZE));
    mem_raddr = rd_addr[ADDR_W-1:0];

    limit_hit = (walk_dist >= {2'b00, max_distance});

    // tile RAM write port: clearing pass or tile write request
    mem_we    = 1'b0;
    mem_waddr = wr_addr[ADDR_W-1:0];
    mem_wdata = tile_solid;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = 1'b0;
    end else if (accept && operation == OP_WRITE && wr_addr < 12'(STORE_SIZE)) begin
      mem_we = 1'b1;
    end

    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == ADDR_W'(STORE_SIZE - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept && operation == OP_CAST) state_next = ST_PREP;
      ST_PREP:   state_next = (dx_c == 17'sd0 && dy_c == 17'sd0) ? ST_IDLE : ST_SQ_A;
      ST_SQ_A:   state_next = ST_SQ_B;
      ST_SQ_B:   state_next = ST_SQRT;
      ST_SQRT:   if (sqrt_k == 5'd0) state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == 6'd33) begin
          case (div_sel)
            DIV_UX:  state_next = ST_DIV;
            DIV_UY:  state_next = ST_SIDE_X;
            DIV_QX:  state_next = ST_HPY;
            DIV_QY:  state_next = ST_EMIT;
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_SIDE_X: state_next = ST_SIDE_Y;
      ST_SIDE_Y: state_next = ST_WALK;
      ST_WALK:   state_next = limit_hit ? ST_EMIT : ST_CHECK;
      ST_CHECK:  state_next = (inb && mem_rdata) ? ST_HPX : ST_WALK;
      ST_HPX:    state_next = ST_DIV;
      ST_HPY:    state_next = ST_DIV;
      ST_EMIT:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EMIT) ||
              (state == ST_PREP && dx_c == 17'sd0 && dy_c == 17'sd0);
    end
  end

  // Cast datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // capture the ray endpoints
        sx <= start_x;
        sy <= start_y;
        tx <= target_x;
        ty <= target_y;
      end
      ST_PREP: begin
        negx <= dx_c[16];
        negy <= dy_c[16];
        ax   <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
        ay   <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
        if (dx_c == 17'sd0 && dy_c == 17'sd0) begin
          // degenerate ray: report it and skip the walk
          hit            <= 1'b0;
          hit_distance   <= '0;
          hit_point_x    <= '0;
          hit_point_y    <= '0;
          hit_cell_col   <= '0;
          hit_cell_row   <= '0;
          zero_direction <= 1'b1;
        end
      end
      ST_SQ_A: sq <= 33'(ax) * 33'(ax);
      ST_SQ_B: begin
        sq     <= sq + 33'(ay) * 33'(ay);
        root   <= '0;
        sqrt_k <= 5'd16;
      end
      ST_SQRT: begin
        if (sqrt_ge) begin
          sq <= sq - sqrt_trial[32:0];
        end
        root   <= root_nx;
        sqrt_k <= sqrt_k - 5'd1;
        if (sqrt_k == 5'd0) begin
          // launch the x unit step: len * ONE / |dx|
          len     <= root_nx[16:0];
          dvd     <= 34'(root_nx[16:0]) << FRAC_BITS;
          dvs     <= {1'b0, ax};
          rem     <= '0;
          div_cnt <= '0;
          div_sel <= DIV_UX;
        end
      end
      ST_DIV: begin
        if (div_cnt == 6'd33 && div_sel == DIV_UX) begin
          // x step done: launch the y unit step
          ux      <= (ax == 16'd0) ? STEP_SAT : quo[31:0];
          dvd     <= 34'(len) << FRAC_BITS;
          dvs     <= {1'b0, ay};
          rem     <= '0;
          div_cnt <= '0;
          div_sel <= DIV_UY;
        end else begin
          rem     <= div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
          dvd     <= quo;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd33) begin
            case (div_sel)
              DIV_UY:  uy <= (ay == 16'd0) ? STEP_SAT : quo[31:0];
              DIV_QX:  qx <= quo[17:0];
              DIV_QY:  qy <= quo[17:0];
              default: ;
            endcase
          end
        end
      end
      ST_SIDE_X: begin
        sidex     <= 34'(side_prod >> FRAC_BITS);
        cx        <= {{(CELL_W - 16 + FRAC_BITS){sx[15]}}, sx[15:FRAC_BITS]};
        cy        <= {{(CELL_W - 16 + FRAC_BITS){sy[15]}}, sy[15:FRAC_BITS]};
        walk_dist <= '0;
        found     <= 1'b0;
      end
      ST_SIDE_Y: sidey <= 34'(side_prod >> FRAC_BITS);
      ST_WALK: begin
        if (!limit_hit) begin
          // advance one cell; the RAM read of that cell is in flight
          cx  <= cx_n;
          cy  <= cy_n;
          inb <= inb_c;
          if (take_x) begin
            walk_dist <= sidex[17:0];
            sidex     <= sidex + 34'(ux);
          end else begin
            walk_dist <= sidey[17:0];
            sidey     <= sidey + 34'(uy);
          end
        end
      end
      ST_CHECK: begin
        if (inb && mem_rdata) begin
          found <= 1'b1;
        end
      end
      ST_HPX: begin
        dvd     <= 34'(ax) * 34'(walk_dist);
        dvs     <= len;
        rem     <= '0;
        div_cnt <= '0;
        div_sel <= DIV_QX;
      end
      ST_HPY: begin
        dvd     <= 34'(ay) * 34'(walk_dist);
        dvs     <= len;
        rem     <= '0;
        div_cnt <= '0;
        div_sel <= DIV_QY;
      end
      ST_EMIT: begin
        hit            <= found;
        hit_distance   <= (walk_dist > 18'hFFFF) ? 16'hFFFF : walk_dist[15:0];
        hit_cell_col   <= cx[7:0];
        hit_cell_row   <= cy[7:0];
        zero_direction <= 1'b0;
        if (found) begin
          hit_point_x <= sat16(negx ? 20'(sx) - 20'(qx) : 20'(sx) + 20'(qx));
          hit_point_y <= sat16(negy ? 20'(sy) - 20'(qy) : 20'(sy) + 20'(qy));
        end else begin
          hit_point_x <= '0;
          hit_point_y <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/grdda_chk.sv =====
// ---------------------------------------------------------------------------
// grdda_chk
// Port-level checks of the grid ray DDA traversal block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module grdda_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               operation,
  input logic               done,
  input logic               hit,
  input logic signed [15:0] hit_point_x,
  input logic signed [15:0] hit_point_y,
  input logic               zero_direction
);

  `ASSERT_CLK(a_done_single, done |=> !done, "result strobe held for two cycles")
  `ASSERT_CLK(a_cast_busy, (start && !busy && operation) |=> busy, "cast request not taken")
  `ASSERT_NEVER(a_zero_no_hit, done && hit && zero_direction, "hit on a degenerate ray")
  `ASSERT_CLK(a_miss_point, (done && !hit) |-> (hit_point_x == 16'sd0 && hit_point_y == 16'sd0),
              "hit point not cleared on a miss")

endmodule

bind grid_ray_dda_traversal grdda_chk u_grdda_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .operation      (operation),
  .done           (done),
  .hit            (hit),
  .hit_point_x    (hit_point_x),
  .hit_point_y    (hit_point_y),
  .zero_direction (zero_direction)
);
